>>> design/nec_ir_frame_transmitter_defines.svh
// assertion macros for the frame transmitter core (nec_ir_core)
`ifndef NEC_IR_FRAME_TRANSMITTER_DEFINES_SVH
`define NEC_IR_FRAME_TRANSMITTER_DEFINES_SVH

`ifndef ASSERT_OFF

// clocked assertion, held off while reset is high
`define NEC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked assertion that also checks across reset
`define NEC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`else

`define NEC_ASSERT(lbl, clk, rst, prop, msg)
`define NEC_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

>>> design/nec_ir_pkg.sv
`default_nettype none

package nec_ir_pkg;

  // frame shape
  localparam int WORD_W         = 32;
  localparam int BYTE_W         = 8;
  localparam int FRAME_BITS_DEF = 32;
  localparam int TIME_W         = 14;

  // segment timing in microsecond ticks
  localparam logic [TIME_W-1:0] LEAD_MARK      = TIME_W'(9000);
  localparam logic [TIME_W-1:0] LEAD_TOTAL     = TIME_W'(9000 + 4500);
  localparam logic [TIME_W-1:0] BIT_MARK       = TIME_W'(560);
  localparam logic [TIME_W-1:0] BIT_ZERO_TOTAL = TIME_W'(560 + 560);
  localparam logic [TIME_W-1:0] BIT_ONE_TOTAL  = TIME_W'(1680 + 560);
  localparam logic [TIME_W-1:0] STOP_MARK      = TIME_W'(300);
  localparam logic [TIME_W-1:0] STOP_TOTAL     = TIME_W'(600);

  // request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_DATA,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] command_byte;
    logic [BYTE_W-1:0] address_byte;
  } req_t;

  typedef struct packed {
    logic mark_on;
    logic busy_res;
    logic frame_done;
  } res_t;

endpackage

`default_nettype wire

>>> design/nec_ir_ifs.sv
`default_nettype none

// request channel: ticks and frame starts
interface nec_ir_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] command_byte;
  logic [7:0] address_byte;

  modport source (output valid, output req_type, output command_byte,
                  output address_byte, input ready);
  modport sink (input valid, input req_type, input command_byte,
                input address_byte, output ready);
endinterface

// result channel: one envelope sample per request
interface nec_ir_res_if;
  logic valid;
  logic ready;
  logic mark_on;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output mark_on, output busy_res,
                  output frame_done, input ready);
  modport sink (input valid, input mark_on, input busy_res,
                input frame_done, output ready);
endinterface

`default_nettype wire

>>> design/nec_ir_frame_transmitter.sv
// NEC-style infrared frame transmitter, mark envelope only (no 38 kHz carrier).
// Every request is either a one-microsecond tick or a frame start carrying a
// command byte and an address byte; every request yields exactly one result
// with the envelope level for that microsecond, a busy flag and a frame-done
// strobe. A frame is a 9000 us mark, a 4500 us space, then FRAME_BITS bits of
// {command, ~command, address, ~address} MSB first (560 us mark, bit length
// 1120 us for a 0 or 2240 us for a 1), then a 300 us mark and a 300 us space.
// A start that arrives while a frame is going out is answered but ignored.
// Throughput is one request per clock unless the sink stalls; each request
// passes the request register and then the result register, with the frame
// state updated as a request leaves the request register. While a stalled sink
// holds a result in the result register, the request register still takes
// one more request, after which req.ready stays low until the sink takes it.
`default_nettype none

module nec_ir_frame_transmitter
  import nec_ir_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input wire            clk,
  input wire            rst,
  nec_ir_req_if.sink    req,
  nec_ir_res_if.source  res
);

  // request register
  logic s1_valid;
  req_t s1_item;
  logic s1_adv;

  // result register
  logic out_valid;
  res_t out_res;
  res_t core_res;

  // the request register moves on whenever the result register is free or
  // is being emptied by a transfer in the same cycle
  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= '{req_type:     req.req_type,
                   command_byte: req.command_byte,
                   address_byte: req.address_byte};
    end
  end

  // frame state and envelope logic; state steps once per request
  nec_ir_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .item   (s1_item),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= core_res;
    end
  end

  assign res.valid      = out_valid;
  assign res.mark_on    = out_res.mark_on;
  assign res.busy_res   = out_res.busy_res;
  assign res.frame_done = out_res.frame_done;

endmodule

`default_nettype wire

>>> design/nec_ir_core.sv
`default_nettype none
`include "nec_ir_frame_transmitter_defines.svh"

module nec_ir_core
  import nec_ir_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  step,
  input  req_t item,
  output res_t result
);

  localparam int CNT_W = $clog2(FRAME_BITS + 1);

  phase_t                  phase, phase_next;
  logic [TIME_W-1:0]       time_count, time_count_next;
  logic [FRAME_BITS-1:0]   shift_word, shift_word_next;
  logic [CNT_W-1:0]        bits_left, bits_left_next;
  logic                    current_bit, current_bit_next;

  logic                    active;
  logic [TIME_W-1:0]       mark_len;
  logic [TIME_W-1:0]       seg_total;
  logic [TIME_W-1:0]       time_inc;
  logic                    seg_end;
  logic [WORD_W-1:0]       load_word;

  assign active    = (phase == PH_LEAD) || (phase == PH_DATA) || (phase == PH_STOP);
  assign time_inc  = time_count + TIME_W'(1);
  assign seg_end   = (time_inc >= seg_total);
  assign load_word = {item.command_byte, ~item.command_byte,
                      item.address_byte, ~item.address_byte};

  // segment lengths of the current phase
  always_comb begin
    case (phase)
      PH_LEAD: begin
        mark_len  = LEAD_MARK;
        seg_total = LEAD_TOTAL;
      end
      PH_DATA: begin
        mark_len  = BIT_MARK;
        seg_total = current_bit ? BIT_ONE_TOTAL : BIT_ZERO_TOTAL;
      end
      PH_STOP: begin
        mark_len  = STOP_MARK;
        seg_total = STOP_TOTAL;
      end
      default: begin
        mark_len  = STOP_MARK;
        seg_total = STOP_TOTAL;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_next       = phase;
    time_count_next  = time_count;
    shift_word_next  = shift_word;
    bits_left_next   = bits_left;
    current_bit_next = current_bit;
    if (item.req_type == REQ_START) begin
      if (!active) begin
        shift_word_next  = load_word[WORD_W-1 -: FRAME_BITS];
        bits_left_next   = CNT_W'(FRAME_BITS);
        current_bit_next = 1'b0;
        time_count_next  = '0;
        phase_next       = PH_LEAD;
      end
    end else if (active) begin
      time_count_next = time_inc;
      if (seg_end) begin
        time_count_next = '0;
        if (phase == PH_STOP) begin
          phase_next = PH_IDLE;
        end else if (bits_left == '0) begin
          phase_next = PH_STOP;
        end else begin
          current_bit_next = shift_word[FRAME_BITS-1];
          shift_word_next  = {shift_word[FRAME_BITS-2:0], 1'b0};
          bits_left_next   = bits_left - CNT_W'(1);
          phase_next       = PH_DATA;
        end
      end
    end
  end

  // envelope sample for this request
  always_comb begin
    result = '0;
    if (item.req_type == REQ_START) begin
      result.busy_res = 1'b1;
    end else if (active) begin
      result.busy_res   = 1'b1;
      result.mark_on    = (time_count < mark_len);
      result.frame_done = seg_end && (phase == PH_STOP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      time_count  <= '0;
      shift_word  <= '0;
      bits_left   <= '0;
      current_bit <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      time_count  <= time_count_next;
      shift_word  <= shift_word_next;
      bits_left   <= bits_left_next;
      current_bit <= current_bit_next;
    end
  end

  `NEC_ASSERT_NR(a_reset_idle, clk, rst |=> phase == PH_IDLE, "phase not idle after reset")
  `NEC_ASSERT(a_done_to_idle, clk, rst, step && result.frame_done |=> phase == PH_IDLE, "frame end did not return to idle")
  `NEC_ASSERT(a_start_loads, clk, rst, step && item.req_type == REQ_START && phase == PH_IDLE |=> phase == PH_LEAD && bits_left == CNT_W'(FRAME_BITS), "start from idle did not load a frame")
  `NEC_ASSERT(a_idle_count_zero, clk, rst, phase == PH_IDLE |-> time_count == '0, "segment timer running while idle")
  `NEC_ASSERT(a_hold_no_step, clk, rst, !step |=> $stable(phase) && $stable(time_count), "state moved without a request")

endmodule

`default_nettype wire

>>> tb/sv/nec_ir_envelope_checker.sv
`timescale 1ns / 100ps

module nec_ir_envelope_checker
  import nec_ir_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  nec_ir_req_if      req,
  nec_ir_res_if      res,
  output int         fail_count,
  output int         outstanding
);

  localparam int MAX_PRINTS = 100;

  // predicted frame state
  phase_t            phase;
  logic [TIME_W-1:0] seg_ticks;
  logic [WORD_W-1:0] word_left;
  logic [5:0]        bits_left;
  logic              cur_bit;

  res_t   envelope_q[$];
  longint result_idx;

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) begin
      $display("[%0t] result %0d: %s", $realtime, result_idx, msg);
    end
    fail_count++;
  endtask

  // advance the frame state by one request and give the envelope sample
  task automatic encode_request(input req_t r, output res_t o);
    logic [TIME_W-1:0] mark_len;
    logic [TIME_W-1:0] seg_len;
    o = '0;
    if (r.req_type == REQ_START) begin
      if (phase == PH_IDLE) begin
        word_left = {r.command_byte, ~r.command_byte, r.address_byte, ~r.address_byte};
        bits_left = 6'(FRAME_BITS);
        cur_bit   = 1'b0;
        seg_ticks = '0;
        phase     = PH_LEAD;
      end
      o.busy_res = 1'b1;
    end else if (phase != PH_IDLE) begin
      o.busy_res = 1'b1;
      case (phase)
        PH_LEAD: begin
          mark_len = LEAD_MARK;
          seg_len  = LEAD_TOTAL;
        end
        PH_DATA: begin
          mark_len = BIT_MARK;
          seg_len  = cur_bit ? BIT_ONE_TOTAL : BIT_ZERO_TOTAL;
        end
        default: begin
          mark_len = STOP_MARK;
          seg_len  = STOP_TOTAL;
        end
      endcase
      o.mark_on = (seg_ticks < mark_len);
      seg_ticks = seg_ticks + 1'b1;
      if (seg_ticks >= seg_len) begin
        seg_ticks = '0;
        if (phase == PH_STOP) begin
          o.frame_done = 1'b1;
          phase        = PH_IDLE;
        end else if (bits_left == '0) begin
          phase = PH_STOP;
        end else begin
          cur_bit   = word_left[WORD_W-1];
          word_left = word_left << 1;
          bits_left = bits_left - 1'b1;
          phase     = PH_DATA;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    req_t got_req;
    res_t want;
    res_t got;
    if (rst) begin
      phase      = PH_IDLE;
      seg_ticks  = '0;
      word_left  = '0;
      bits_left  = '0;
      cur_bit    = 1'b0;
      result_idx = 0;
      fail_count = 0;
      envelope_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        got_req = {req.req_type, req.command_byte, req.address_byte};
        encode_request(got_req, want);
        envelope_q.push_back(want);
      end
      if (res.valid && res.ready) begin
        got = {res.mark_on, res.busy_res, res.frame_done};
        if (envelope_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = envelope_q.pop_front();
          if (got.mark_on !== want.mark_on)
            report_mismatch($sformatf("mark_on %b, want %b", got.mark_on, want.mark_on));
          if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
          if (got.frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done %b, want %b",
                                      got.frame_done, want.frame_done));
        end
        result_idx++;
      end
    end
    outstanding = envelope_q.size();
  end

endmodule

>>> tb/sv/tb_nec_ir_frame_transmitter.sv
`timescale 1ns / 100ps

module tb_nec_ir_frame_transmitter;
  import nec_ir_pkg::*;

  localparam int FRAME_BITS   = FRAME_BITS_DEF;
  localparam int N_ITEMS      = 500;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   quiet_cycles;
  bit   gappy;  // sender idles between requests when set

  // sink stall control
  bit stall_mode;
  int stall_left;

  nec_ir_req_if req_ch ();
  nec_ir_res_if res_ch ();

  nec_ir_frame_transmitter #(
    .FRAME_BITS(FRAME_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // watches both channels, predicts every envelope sample and compares
  nec_ir_envelope_checker #(
    .FRAME_BITS(FRAME_BITS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int idle_gap();
    int pick;
    if (!gappy) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 85) return 0;
    if (pick < 98) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // one request transfer; valid stays high after acceptance until the next
  // call either drops it for a gap or replaces the payload
  task automatic send_req(input logic kind, input logic [7:0] cmd,
                          input logic [7:0] addr);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.command_byte <= cmd;
    req_ch.address_byte <= addr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // tick payload bytes are don't-care, so randomize them anyway
  task automatic send_tick();
    send_req(REQ_TICK, 8'($urandom), 8'($urandom));
  endtask

  // result side back-pressure, in stretches with and without stalls
  always @(negedge clk) begin
    int pick;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_mode = 1'b1;
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
      if (!stall_mode) begin
        res_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 10) stall_left = $urandom_range(1, 3);
        else if (pick < 12) stall_left = $urandom_range(4, 25);
      end
    end
  end

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_TICK;
    req_ch.command_byte = 8'h00;
    req_ch.address_byte = 8'h00;
    res_ch.ready        = 1'b0;
    rst                 = 1'b1;
    gappy               = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // ticks while idle must give an all-zero sample
    send_req(REQ_TICK, 8'h00, 8'h00);
    send_req(REQ_TICK, 8'hFF, 8'hFF);
    // all-ones command with all-zeros address, then starts during the leader
    send_req(REQ_START, 8'hFF, 8'h00);
    send_req(REQ_START, 8'h00, 8'hFF);
    send_tick();
    send_req(REQ_START, 8'h55, 8'hAA);

    // leader ticks mixed with starts that must be ignored, idling in stretches
    gappy = 1'b1;
    for (int i = 6; i < N_ITEMS; i++) begin
      if ($urandom_range(0, 99) == 0) gappy = !gappy;
      if ($urandom_range(0, 24) == 0) begin
        send_req(REQ_START, 8'($urandom), 8'($urandom));
      end else begin
        send_tick();
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // let the last samples come back, then wait DRAIN_CYCLES more for strays
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang detection: too long without a transfer on either channel
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
